// ----- sv/i2c_master_register_access_assert.svh -----
// Assertion macros used by i2c_master_register_access.sv. They rely on clk and arst_n in scope.
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define I2CM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, idle during reset.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

	localparam int unsigned DevW = 7;
	localparam int unsigned ByteW = 8;
	localparam int unsigned BitCntW = 3;

	// Item kinds carried on the slave tuser.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Byte being shifted out; in the stop sequence the same field holds the error code.
	localparam logic [1:0] W_DEVW = 2'd0;
	localparam logic [1:0] W_REG  = 2'd1;
	localparam logic [1:0] W_DATA = 2'd2;
	localparam logic [1:0] W_DEVR = 2'd3;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_DEV  = 2'd1;
	localparam logic [1:0] ERR_REG  = 2'd2;
	localparam logic [1:0] ERR_DATA = 2'd3;

	localparam logic [ByteW-1:0] READ_BIT = 8'h01;

	typedef enum logic [3:0] {
		K_IDLE  = 4'd0,
		K_BEGIN = 4'd1,
		K_BSET  = 4'd2,
		K_BHI   = 4'd3,
		K_BLO   = 4'd4,
		K_AREL  = 4'd5,
		K_AHI   = 4'd6,
		K_RLO   = 4'd7,
		K_RHI   = 4'd8,
		K_KSET  = 4'd9,
		K_KHI   = 4'd10,
		K_KLO   = 4'd11,
		K_END   = 4'd12
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [1:0]         what;
		logic [BitCntW-1:0] bit_cnt;
		logic [ByteW-1:0]   shift_byte;
		logic [ByteW-1:0]   bytes_done;
		logic [DevW-1:0]    saved_device;
		logic [ByteW-1:0]   saved_register;
		logic               is_read;
		logic [ByteW-1:0]   saved_length;
		logic               scl;
		logic               sda;
	} state_t;

	localparam state_t STATE_RESET = '{
		kind: K_IDLE, what: 2'd0, bit_cnt: '0, shift_byte: '0, bytes_done: '0,
		saved_device: '0, saved_register: '0, is_read: 1'b0, saved_length: '0,
		scl: 1'b1, sda: 1'b1
	};

	typedef struct packed {
		logic [DevW-1:0]  dev_addr;
		logic [ByteW-1:0] reg_addr;
		logic [ByteW-1:0] length;
		logic [ByteW-1:0] write_byte;
		logic             sda_in;
	} item_t;

	typedef struct packed {
		logic             scl_level;
		logic             sda_level;
		logic             busy_res;
		logic             byte_taken;
		logic [ByteW-1:0] read_byte;
		logic             read_valid;
		logic             last_byte;
		logic             done_res;
		logic [1:0]       error_code;
	} res_t;

endpackage

`default_nettype wire

// ----- sv/i2c_master_register_access.sv -----
// Channel  | Beat                                   | Handshake
// ---------+----------------------------------------+----------------------------
// s_       | tuser cmd; tdata dev, reg, length,     | s_tvalid & s_tready
//          | write_byte, sda_in                     |
// m_       | tdata levels, flags, read byte, error; | m_tvalid & m_tready
//          | tlast last read byte                   |
//
// One beat in, one beat out; a new input beat may be taken every cycle.
// An item passes the input register, then the phase logic into the result register.
// The phase logic is a single pass over the controller state; nothing iterates.
// The input stage keeps accepting while a result waits, until both registers are full.
// arst_n clears the controller to idle with SCL and SDA released high.
`default_nettype none

`include "i2c_master_register_access_assert.svh"

module i2c_master_register_access (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // dev_addr[6:0], reg_addr[14:7], length[22:15],
	                                   // write_byte[30:23], sda_in[31]
	input  wire logic [1:0]  s_tuser,  // cmd[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // scl_level[0], sda_level[1], busy_res[2],
	                                   // byte_taken[3], read_byte[11:4], read_valid[12],
	                                   // done_res[13], error_code[15:14]
	output logic             m_tlast   // last_byte
);

	logic              vld_s1;
	logic [1:0]        cmd_s1;
	i2cm_pkg::item_t   item_s1;
	i2cm_pkg::state_t  state_q;
	i2cm_pkg::state_t  state_nxt;
	i2cm_pkg::res_t    res_nxt;
	i2cm_pkg::res_t    res_q;
	logic              m_vld_q;
	logic              adv;
	logic              fire;

	// result register can take a beat when empty or being drained
	assign adv = !m_vld_q || m_tready;
	assign s_tready = !vld_s1 || adv;
	assign fire = vld_s1 && adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= s_tuser;
			item_s1.dev_addr <= s_tdata[6:0];
			item_s1.reg_addr <= s_tdata[14:7];
			item_s1.length <= s_tdata[22:15];
			item_s1.write_byte <= s_tdata[30:23];
			item_s1.sda_in <= s_tdata[31];
		end
	end

	i2cm_step u_step (
		.st   (state_q),
		.cmd  (cmd_s1),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// advance the bus controller only when the phase result is taken into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2cm_pkg::STATE_RESET;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// result stage: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (fire) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata = {res_q.error_code, res_q.done_res, res_q.read_valid, res_q.read_byte,
		res_q.byte_taken, res_q.busy_res, res_q.sda_level, res_q.scl_level};
	assign m_tlast = res_q.last_byte;

	`I2CM_ASSERT_NOW(a_done_ends_busy, m_vld_q && res_q.done_res, !res_q.busy_res, "done while busy")
	`I2CM_ASSERT_NOW(a_err_needs_done, m_vld_q && (res_q.error_code != i2cm_pkg::ERR_OK), res_q.done_res, "error code without done")
	`I2CM_ASSERT_NOW(a_rx_in_txn, m_vld_q && (res_q.read_valid || res_q.byte_taken), res_q.busy_res, "data beat outside a transaction")
	`I2CM_ASSERT_NEXT(a_state_holds, !fire, $stable(state_q), "controller moved without a beat")
	`I2CM_ASSERT_NOW(a_empty_accepts, !m_vld_q, s_tready, "input stalled with empty output")

endmodule

`default_nettype wire

// ----- sv/i2cm_step.sv -----
`default_nettype none

// One bus phase: next state and the result of one item.
module i2cm_step (
	input  wire i2cm_pkg::state_t st,
	input  wire logic [1:0]       cmd,
	input  wire i2cm_pkg::item_t  item,
	output i2cm_pkg::state_t      nxt,
	output i2cm_pkg::res_t        res
);

	logic                        post_low;
	logic [i2cm_pkg::ByteW-1:0]  load_byte;
	logic [i2cm_pkg::ByteW-1:0]  rx_byte;
	logic [i2cm_pkg::ByteW:0]    done_inc;

	function automatic i2cm_pkg::state_t go(input i2cm_pkg::state_t s,
			input i2cm_pkg::kind_t k, input logic [1:0] w);
		i2cm_pkg::state_t t;
		t = s;
		t.kind = k;
		t.what = w;
		t.bit_cnt = '0;
		return t;
	endfunction

	assign rx_byte = {st.shift_byte[i2cm_pkg::ByteW-2:0], item.sda_in};
	assign done_inc = {1'b0, st.bytes_done} + 9'd1;

	always_comb begin
		case (st.what)
			i2cm_pkg::W_DEVW: load_byte = {st.saved_device, 1'b0};
			i2cm_pkg::W_REG:  load_byte = st.saved_register;
			i2cm_pkg::W_DATA: load_byte = item.write_byte;
			default:          load_byte = {st.saved_device, 1'b0} | i2cm_pkg::READ_BIT;
		endcase
	end

	always_comb begin
		nxt = st;
		post_low = 1'b0;
		res.byte_taken = 1'b0;
		res.read_byte = '0;
		res.read_valid = 1'b0;
		res.last_byte = 1'b0;
		res.done_res = 1'b0;
		res.error_code = i2cm_pkg::ERR_OK;
		if (st.kind == i2cm_pkg::K_IDLE) begin
			if (cmd == i2cm_pkg::CMD_WRITE || cmd == i2cm_pkg::CMD_READ) begin
				nxt.saved_device = item.dev_addr;
				nxt.saved_register = item.reg_addr;
				nxt.saved_length = item.length;
				nxt.is_read = (cmd == i2cm_pkg::CMD_READ);
				nxt.bytes_done = '0;
				nxt.shift_byte = '0;
				nxt = go(nxt, i2cm_pkg::K_BEGIN, 2'd0);
			end
		end else if (cmd == i2cm_pkg::CMD_TICK) begin
			case (st.kind)
				i2cm_pkg::K_BEGIN: begin
					case (st.bit_cnt)
						3'd0:    nxt.sda = 1'b1;
						3'd1:    nxt.scl = 1'b1;
						3'd2:    nxt.sda = 1'b0;
						default: nxt.scl = 1'b0;
					endcase
					if (st.bit_cnt >= 3'd3) begin
						nxt = go(nxt, i2cm_pkg::K_BSET,
							(st.what == 2'd0) ? i2cm_pkg::W_DEVW : i2cm_pkg::W_DEVR);
					end else begin
						nxt.bit_cnt = st.bit_cnt + 3'd1;
					end
				end
				i2cm_pkg::K_BSET: begin
					if (st.bit_cnt == 3'd0) begin
						nxt.sda = load_byte[i2cm_pkg::ByteW-1];
						nxt.shift_byte = {load_byte[i2cm_pkg::ByteW-2:0], 1'b0};
						res.byte_taken = (st.what == i2cm_pkg::W_DATA);
					end else begin
						nxt.sda = st.shift_byte[i2cm_pkg::ByteW-1];
						nxt.shift_byte = {st.shift_byte[i2cm_pkg::ByteW-2:0], 1'b0};
					end
					nxt.kind = i2cm_pkg::K_BHI;
				end
				i2cm_pkg::K_BHI: begin
					nxt.scl = 1'b1;
					nxt.kind = i2cm_pkg::K_BLO;
				end
				i2cm_pkg::K_BLO: begin
					nxt.scl = 1'b0;
					if (st.bit_cnt == 3'd7) begin
						nxt = go(nxt, i2cm_pkg::K_AREL, st.what);
					end else begin
						nxt.bit_cnt = st.bit_cnt + 3'd1;
						nxt.kind = i2cm_pkg::K_BSET;
					end
				end
				i2cm_pkg::K_AREL: begin
					nxt.sda = 1'b1;
					nxt.kind = i2cm_pkg::K_AHI;
				end
				i2cm_pkg::K_AHI: begin
					nxt.scl = 1'b1;
					nxt.sda = 1'b1;
					post_low = 1'b1;
					if (item.sda_in) begin
						case (st.what)
							i2cm_pkg::W_DEVW: nxt = go(nxt, i2cm_pkg::K_END, i2cm_pkg::ERR_DEV);
							i2cm_pkg::W_REG:  nxt = go(nxt, i2cm_pkg::K_END, i2cm_pkg::ERR_REG);
							default:          nxt = go(nxt, i2cm_pkg::K_END, i2cm_pkg::ERR_DATA);
						endcase
					end else begin
						case (st.what)
							i2cm_pkg::W_DEVW: nxt = go(nxt, i2cm_pkg::K_BSET, i2cm_pkg::W_REG);
							i2cm_pkg::W_REG: begin
								if (st.is_read)
									nxt = go(nxt, i2cm_pkg::K_BEGIN, 2'd1);
								else if (st.saved_length == '0)
									nxt = go(nxt, i2cm_pkg::K_END, i2cm_pkg::ERR_OK);
								else
									nxt = go(nxt, i2cm_pkg::K_BSET, i2cm_pkg::W_DATA);
							end
							i2cm_pkg::W_DATA: begin
								nxt.bytes_done = done_inc[i2cm_pkg::ByteW-1:0];
								if (done_inc[i2cm_pkg::ByteW-1:0] == st.saved_length)
									nxt = go(nxt, i2cm_pkg::K_END, i2cm_pkg::ERR_OK);
								else
									nxt = go(nxt, i2cm_pkg::K_BSET, i2cm_pkg::W_DATA);
							end
							default: begin
								if (st.saved_length == '0) begin
									nxt = go(nxt, i2cm_pkg::K_END, i2cm_pkg::ERR_OK);
								end else begin
									nxt.shift_byte = '0;
									nxt = go(nxt, i2cm_pkg::K_RLO, 2'd0);
								end
							end
						endcase
					end
				end
				i2cm_pkg::K_RLO: begin
					nxt.scl = 1'b0;
					nxt.sda = 1'b1;
					nxt.kind = i2cm_pkg::K_RHI;
					nxt.what = 2'd0;
				end
				i2cm_pkg::K_RHI: begin
					nxt.scl = 1'b1;
					nxt.shift_byte = rx_byte;
					if (st.bit_cnt == 3'd7) begin
						post_low = 1'b1;
						res.read_byte = rx_byte;
						res.read_valid = 1'b1;
						res.last_byte = (done_inc == {1'b0, st.saved_length});
						nxt.bytes_done = done_inc[i2cm_pkg::ByteW-1:0];
						nxt = go(nxt, i2cm_pkg::K_KSET, 2'd0);
					end else begin
						nxt.bit_cnt = st.bit_cnt + 3'd1;
						nxt.kind = i2cm_pkg::K_RLO;
						nxt.what = 2'd0;
					end
				end
				i2cm_pkg::K_KSET: begin
					nxt.sda = (st.bytes_done == st.saved_length);
					nxt.kind = i2cm_pkg::K_KHI;
				end
				i2cm_pkg::K_KHI: begin
					nxt.scl = 1'b1;
					nxt.kind = i2cm_pkg::K_KLO;
				end
				i2cm_pkg::K_KLO: begin
					nxt.scl = 1'b0;
					if (st.bytes_done == st.saved_length) begin
						nxt = go(nxt, i2cm_pkg::K_END, i2cm_pkg::ERR_OK);
					end else begin
						nxt.shift_byte = '0;
						nxt = go(nxt, i2cm_pkg::K_RLO, 2'd0);
					end
				end
				i2cm_pkg::K_END: begin
					if (st.bit_cnt == 3'd0) begin
						nxt.sda = 1'b0;
						nxt.bit_cnt = 3'd1;
					end else if (st.bit_cnt == 3'd1) begin
						nxt.scl = 1'b1;
						nxt.bit_cnt = 3'd2;
					end else begin
						nxt.sda = 1'b1;
						res.done_res = 1'b1;
						res.error_code = st.what;
						nxt = go(nxt, i2cm_pkg::K_IDLE, 2'd0);
					end
				end
				default: nxt = go(nxt, i2cm_pkg::K_IDLE, 2'd0);
			endcase
		end
		// report the levels of this phase, then drop SCL after an ACK or last-bit sample
		res.scl_level = nxt.scl;
		res.sda_level = nxt.sda;
		res.busy_res = (nxt.kind != i2cm_pkg::K_IDLE);
		if (post_low)
			nxt.scl = 1'b0;
	end

endmodule

`default_nettype wire
